// ===== sv/elf_pkg.sv =====
// Shared widths, constants and control types for the echo level filter.
package elf_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
  localparam int LVL_W      = 7;
  localparam int ECHO_W     = 20;
  localparam int HGT_W      = 16;
  localparam int CFG_W      = 16;
  localparam int NUM_W      = ECHO_W + 5;
  localparam int DEN_W      = HGT_W;
  localparam int DCNT_W     = $clog2(NUM_W);
  localparam int SUM_W      = $clog2(MAX_WINDOW * 127 + 1);
  localparam int SCORE_W    = 7;

  localparam logic [HGT_W-1:0] HEIGHT_RST = 16'd1000;
  localparam logic [WIN_W-1:0] WINDOW_RST = WIN_W'(8);

  localparam logic [SCORE_W-1:0] SCORE_LIMIT = 7'd100;
  localparam logic [SCORE_W-1:0] SCORE_UP    = 7'd10;
  localparam logic [SCORE_W-1:0] SCORE_DOWN  = 7'd2;
  localparam logic [7:0]         SLEW_BAND   = 8'd20;
  localparam logic [7:0]         SLEW_STEP   = 8'd5;
  localparam logic [7:0]         LEVEL_FULL  = 8'd100;
  localparam logic [7:0]         LEVEL_OFF   = 8'hFF;

  localparam logic CFG_HEIGHT = 1'b0;
  localparam logic CFG_WINDOW = 1'b1;

  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  // Per-cell control: load a new value, and take it from the right-hand neighbor
  // instead of the injected value.
  typedef struct packed {
    logic load;
    logic from_next;
  } cell_ctrl_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

endpackage

// ===== sv/elf_cell.sv =====
// One history cell of the level window: holds an entry, shifts from its neighbor.
module elf_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  elf_pkg::cell_ctrl_t          ctrl,
  input  logic [elf_pkg::LVL_W-1:0]    next_val,
  input  logic [elf_pkg::LVL_W-1:0]    inj_val,
  output logic [elf_pkg::LVL_W-1:0]    val
);
  import elf_pkg::*;

  logic [LVL_W-1:0] val_r;
  logic [LVL_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.load) begin
      val_nxt = ctrl.from_next ? next_val : inj_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

// ===== sv/elf_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module elf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  elf_pkg::div_ctrl_t          ctrl,
  input  logic [elf_pkg::NUM_W-1:0]   num,
  input  logic [elf_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [elf_pkg::NUM_W-1:0]   quo,
  output logic [elf_pkg::DEN_W-1:0]   rem
);
  import elf_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W:0]    part;
  logic [DEN_W:0]    diff;

  always_comb begin
    part     = {rem_r, quo_r[NUM_W-1]};
    diff     = part - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (part >= {1'b0, den_r}) begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = part[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== sv/echo_level_filter.sv =====
// Top level: echo width to fill level, fault scoring and window averaging.
// A good sample runs two serial divisions in one shared divider, a window rotation through
// the cell row and the fill/shift/output steps, with the fill step only on the first sample
// after reset or a restart. Faults and disabled samples skip the divider and go straight to
// the output step; restarts give none. One item is in work at a time; the next input is
// taken once the result is parked in the output register.
// Synchronous active-low reset: history cells clear to zero; control, score, flags and
// config go to reset values.
module echo_level_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [19:0] echo_us, [23:20] zero
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] level_pct
  output logic [1:0]  out_tuser,  // [0] fault, [1] disabled
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_wdata
);
  import elf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV1  = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_ROT   = 3'd4;
  localparam logic [2:0] S_DIV2  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [HGT_W-1:0]   height_r, height_nxt;
  logic [WIN_W-1:0]   window_r, window_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic               boot_r, boot_nxt;
  logic               dis_r, dis_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [7:0]         res_lvl_r, res_lvl_nxt;
  logic               res_fault_r, res_fault_nxt;
  logic               res_dis_r, res_dis_nxt;
  logic               ov_r, ov_nxt;
  logic [7:0]         ol_r, ol_nxt;
  logic               of_r, of_nxt;
  logic               od_r, od_nxt;

  logic               in_xfer;
  logic [ECHO_W-1:0]  echo;
  logic               echo_zero;
  logic [WIN_W-1:0]   w_eff;
  logic [IDX_W-1:0]   wm1;
  logic [HGT_W-1:0]   h_eff;
  logic [LVL_W-1:0]   hist [MAX_WINDOW];
  logic [LVL_W-1:0]   last;
  logic [LVL_W-1:0]   inj;
  logic [LVL_W-1:0]   slewed;
  logic [7:0]         last_ext;
  logic [7:0]         lvl_ext;
  cell_ctrl_t         cctrl [MAX_WINDOW];

  div_ctrl_t          dctrl;
  logic [NUM_W-1:0]   dnum;
  logic [DEN_W-1:0]   dden;
  logic               ddone;
  logic [NUM_W-1:0]   dquo;
  logic [DEN_W-1:0]   drem;
  logic               rnz;
  logic               over;
  logic               slot_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign echo      = in_tdata[ECHO_W-1:0];
  assign echo_zero = (echo == '0);
  assign slot_free = !ov_r || out_tready;

  always_comb begin
    w_eff = window_r;
    if (window_r == '0) begin
      w_eff = WIN_W'(1);
    end else if (window_r > WIN_W'(MAX_WINDOW)) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end
  end
  assign wm1   = IDX_W'(w_eff - 1'b1);
  assign h_eff = (height_r == '0) ? HGT_W'(1) : height_r;
  assign last  = hist[wm1];

  // Slew toward the newest entry when the jump is too large.
  always_comb begin
    last_ext = {1'b0, last};
    lvl_ext  = {1'b0, lvl_r};
    slewed   = lvl_r;
    if (lvl_ext > last_ext + SLEW_BAND) begin
      slewed = LVL_W'(last_ext + SLEW_STEP);
    end else if (lvl_ext + SLEW_BAND < last_ext) begin
      slewed = LVL_W'(last_ext - SLEW_STEP);
    end
  end

  always_comb begin
    inj = hist[0];
    case (state_r)
      S_FILL:  inj = lvl_r;
      S_SHIFT: inj = slewed;
      default: inj = hist[0];
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      cctrl[i] = '0;
      if (state_r == S_FILL) begin
        cctrl[i].load = (IDX_W'(i) <= wm1);
      end else if (state_r == S_SHIFT || state_r == S_ROT) begin
        cctrl[i].load      = (IDX_W'(i) <= wm1);
        cctrl[i].from_next = (IDX_W'(i) < wm1);
      end
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    if (i < MAX_WINDOW - 1) begin : g_mid
      elf_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cctrl[i]),
        .next_val (hist[i+1]),
        .inj_val  (inj),
        .val      (hist[i])
      );
    end else begin : g_end
      elf_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cctrl[i]),
        .next_val ('0),
        .inj_val  (inj),
        .val      (hist[i])
      );
    end
  end

  always_comb begin
    dctrl.start = 1'b0;
    dnum        = ({5'b0, echo} << 4) + {5'b0, echo};
    dden        = h_eff;
    if (state_r == S_ROT) begin
      dnum = NUM_W'(sum_r) + NUM_W'(hist[0]);
      dden = DEN_W'(w_eff);
    end
    if (in_xfer && in_tuser == REQ_SAMPLE && !dis_r && !echo_zero) begin
      dctrl.start = 1'b1;
    end
    if (state_r == S_ROT && cnt_r == wm1) begin
      dctrl.start = 1'b1;
    end
  end

  elf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (dctrl),
    .num   (dnum),
    .den   (dden),
    .done  (ddone),
    .quo   (dquo),
    .rem   (drem)
  );

  assign rnz  = (drem != '0);
  assign over = (dquo >= NUM_W'(LEVEL_FULL)) ||
                ((dquo == NUM_W'(LEVEL_FULL - 1'b1)) && rnz);

  always_comb begin
    state_nxt     = state_r;
    height_nxt    = height_r;
    window_nxt    = window_r;
    score_nxt     = score_r;
    boot_nxt      = boot_r;
    dis_nxt       = dis_r;
    lvl_nxt       = lvl_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    res_lvl_nxt   = res_lvl_r;
    res_fault_nxt = res_fault_r;
    res_dis_nxt   = res_dis_r;
    ov_nxt        = ov_r;
    ol_nxt        = ol_r;
    of_nxt        = of_r;
    od_nxt        = od_r;

    if (cfg_we) begin
      case (cfg_idx)
        CFG_HEIGHT: height_nxt = cfg_wdata[HGT_W-1:0];
        CFG_WINDOW: window_nxt = cfg_wdata[WIN_W-1:0];
        default:    height_nxt = height_r;
      endcase
    end

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_fault_nxt = echo_zero;
          if (in_tuser == REQ_RESTART) begin
            boot_nxt = 1'b1;
            dis_nxt  = 1'b0;
          end else if (dis_r) begin
            res_lvl_nxt = LEVEL_OFF;
            res_dis_nxt = 1'b1;
            state_nxt   = S_OUT;
          end else if (echo_zero) begin
            if (score_r >= SCORE_LIMIT) begin
              dis_nxt     = 1'b1;
              res_lvl_nxt = LEVEL_OFF;
              res_dis_nxt = 1'b1;
            end else begin
              score_nxt   = score_r + SCORE_UP;
              res_lvl_nxt = {1'b0, last};
              res_dis_nxt = 1'b0;
            end
            state_nxt = S_OUT;
          end else begin
            if (score_r >= SCORE_DOWN) begin
              score_nxt = score_r - SCORE_DOWN;
            end
            state_nxt = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        if (ddone) begin
          lvl_nxt   = over ? '0 : LVL_W'(LEVEL_FULL - 8'(dquo[6:0]) - 8'(rnz));
          state_nxt = boot_r ? S_FILL : S_SHIFT;
        end
      end
      S_FILL: begin
        boot_nxt  = 1'b0;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        sum_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        // Rotate the live window once around, adding up the head cell.
        sum_nxt = sum_r + SUM_W'(hist[0]);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == wm1) begin
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        if (ddone) begin
          res_lvl_nxt = dquo[7:0];
          res_fault_nxt = 1'b0;
          res_dis_nxt = 1'b0;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ol_nxt    = res_lvl_r;
          of_nxt    = res_fault_r;
          od_nxt    = res_dis_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      height_r <= HEIGHT_RST;
      window_r <= WINDOW_RST;
      score_r  <= '0;
      boot_r   <= 1'b1;
      dis_r    <= 1'b0;
      ov_r     <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      height_r <= height_nxt;
      window_r <= window_nxt;
      score_r  <= score_nxt;
      boot_r   <= boot_nxt;
      dis_r    <= dis_nxt;
      ov_r     <= ov_nxt;
      cnt_r    <= cnt_nxt;
    end
    lvl_r       <= lvl_nxt;
    sum_r       <= sum_nxt;
    res_lvl_r   <= res_lvl_nxt;
    res_fault_r <= res_fault_nxt;
    res_dis_r   <= res_dis_nxt;
    ol_r        <= ol_nxt;
    of_r        <= of_nxt;
    od_r        <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = ol_r;
  assign out_tuser  = {od_r, of_r};

endmodule

// ===== sv/elf_chk.sv =====
// Port-level checker for the echo level filter, bound to the top level.
module elf_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [1:0]  out_tuser
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed or dropped");

  // A disabled result always reads as minus one.
  a_dis_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == 8'hFF)
    else $error("disabled result without level -1");

  // An enabled result stays within 0..100 percent.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata <= 8'd100)
    else $error("level out of range");

  // Reset leaves the block ready for input.
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("not ready after reset");

endmodule

bind echo_level_filter elf_chk u_elf_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
